FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the telemetry packet scheduler: command and
// packet kind codes, field widths, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

   // field widths
   localparam int CMD_BITS       = 2;
   localparam int STATE_BITS     = 3;
   localparam int KIND_BITS      = 3;
   localparam int STEP_BITS      = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PASS_BITS      = 8;

   // scheduler constants
   localparam int KIND_COUNT     = 6;
   localparam int SEARCH_LIMIT   = 255;

   // walk positions with special handling
   localparam logic [STEP_BITS-1:0] BOOT_STEP      = 3'd4;
   localparam logic [STEP_BITS-1:0] LAST_CELL_STEP = 3'd2;
   localparam logic [STEP_BITS-1:0] LAST_STEP      = 3'(KIND_COUNT - 1);
   localparam logic [PASS_BITS-1:0] LAST_PASS      = 8'(SEARCH_LIMIT - 1);

   // protection states that mean no measurement is running
   localparam logic [STATE_BITS-1:0] SYS_OFF  = 3'd0;
   localparam logic [STATE_BITS-1:0] SYS_HALT = 3'd4;

   // input commands
   typedef enum logic [CMD_BITS-1:0] {
      CMD_SENT  = 2'd0,
      CMD_START = 2'd1,
      CMD_BUS   = 2'd2
   } cmd_type;

   // packet kinds on the result word
   typedef enum logic [KIND_BITS-1:0] {
      KIND_NONE    = 3'd0,
      KIND_STATUS  = 3'd1,
      KIND_VOLTS   = 3'd2,
      KIND_TEMPS   = 3'd3,
      KIND_BALANCE = 3'd4,
      KIND_BOOT    = 3'd5,
      KIND_CHARGE  = 3'd6
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_LOAD   = 2'd2
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic accept;
      logic step_en;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_start;
      logic search_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/tps_req_if.sv
// ----------------------------------------------------------------------------
// tps_req_if
// Request channel: one scheduler command word with the measurement status
// that goes with it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tps_req_if import tps_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [STATE_BITS-1:0] system_state;
   logic                  cells_a_valid;
   logic                  cells_b_valid;
   logic                  boot_a_valid;
   logic                  boot_b_valid;

   modport source (
      output valid, command, system_state, cells_a_valid, cells_b_valid,
             boot_a_valid, boot_b_valid,
      input  ready
   );

   modport sink (
      input  valid, command, system_state, cells_a_valid, cells_b_valid,
             boot_a_valid, boot_b_valid,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/tps_rsp_if.sv
// ----------------------------------------------------------------------------
// tps_rsp_if
// Response channel: the packet kind chosen, its reading set and the sending
// flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tps_rsp_if import tps_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] packet_kind;
   logic                 data_set;
   logic                 sending_active;

   modport source (
      output valid, packet_kind, data_set, sending_active,
      input  ready
   );

   modport sink (
      input  valid, packet_kind, data_set, sending_active,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/tps_csr_if.sv
// ----------------------------------------------------------------------------
// tps_csr_if
// Register write channel: period register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tps_csr_if import tps_pkg::*; #(parameter int DATA_BITS = 8);
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/tps_ctrl.sv
// ----------------------------------------------------------------------------
// tps_ctrl
// Scheduler controller: takes a request word, runs the period search one
// walk step per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ctrl import tps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.req_ready = 1'b0;
      cmd.accept    = 1'b0;
      cmd.step_en   = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.search_start ? ST_SEARCH : ST_LOAD;
            end
         end
         ST_SEARCH: begin
            cmd.step_en = 1'b1;
            if (status.search_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/tps_dpath.sv
// ----------------------------------------------------------------------------
// tps_dpath
// Scheduler datapath: period registers, walk step and cycle count, bus
// handover flags, search pass counter, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_dpath import tps_pkg::*; #(
   parameter int PERIOD_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic [CMD_BITS-1:0]       req_command,
   input  logic [STATE_BITS-1:0]     req_system_state,
   input  logic                      req_cells_a_valid,
   input  logic                      req_cells_b_valid,
   input  logic                      req_boot_a_valid,
   input  logic                      req_boot_b_valid,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PERIOD_BITS-1:0]    csr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [KIND_BITS-1:0]      rsp_packet_kind,
   output logic                      rsp_data_set,
   output logic                      rsp_sending_active
);

   // control state
   logic [PERIOD_BITS-1:0] period_ff [KIND_COUNT];
   logic [PERIOD_BITS-1:0] period_in [KIND_COUNT];
   logic                   bus_wanted_ff, bus_wanted_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [PERIOD_BITS-1:0] count_ff, count_in;
   logic                   sending_ff, sending_in;
   logic                   saved_ff, saved_in;
   logic                   mainline_ff, mainline_in;
   logic                   out_valid_ff, out_valid_in;

   // payload
   logic [PASS_BITS-1:0]   pass_ff, pass_in;
   logic                   cells_set_ff, cells_set_in;
   logic                   boot_a_ff, boot_a_in;
   logic                   boot_b_ff, boot_b_in;
   kind_type               res_kind_ff, res_kind_in;
   logic                   res_set_ff, res_set_in;
   kind_type               out_kind_ff, out_kind_in;
   logic                   out_set_ff, out_set_in;
   logic                   out_sending_ff, out_sending_in;

   // search step terms
   logic [PERIOD_BITS-1:0] max_period;
   logic [PERIOD_BITS-1:0] cur_period;
   logic [PERIOD_BITS-1:0] count_inc;
   logic                   due, skip, found, last, pass_end;
   logic                   no_meas, have_cells, start;

   // largest period as the registers stand now
   always_comb begin
      max_period = '0;
      for (int i = 0; i < KIND_COUNT; i++) begin
         if (period_ff[i] > max_period) begin
            max_period = period_ff[i];
         end
      end
   end

   // period of the kind at the current walk step
   always_comb begin
      cur_period = '0;
      for (int i = 0; i < KIND_COUNT; i++) begin
         if (step_ff == STEP_BITS'(i)) begin
            cur_period = period_ff[i];
         end
      end
   end

   // one walk step: disabled kinds and bootstrap without readings are skipped
   // within the same pass
   assign due       = (count_ff >= cur_period);
   assign skip      = due && ((cur_period == '0) ||
                      ((step_ff == BOOT_STEP) && !boot_a_ff && !boot_b_ff));
   assign found     = due && !skip;
   assign last      = (step_ff == LAST_STEP);
   assign pass_end  = !skip || last;
   assign count_inc = count_ff + PERIOD_BITS'(1);

   // request decode terms
   assign no_meas    = req_system_state inside {SYS_OFF, SYS_HALT};
   assign have_cells = req_cells_a_valid || req_cells_b_valid;
   assign start      = (cmd_type'(req_command) == CMD_SENT) && !bus_wanted_ff &&
                       !no_meas && have_cells;

   assign status.search_start = start;
   assign status.search_done  = found || (pass_end && (pass_ff == LAST_PASS));
   assign status.out_free     = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      period_in      = period_ff;
      bus_wanted_in  = bus_wanted_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      sending_in     = sending_ff;
      saved_in       = saved_ff;
      mainline_in    = mainline_ff;
      pass_in        = pass_ff;
      cells_set_in   = cells_set_ff;
      boot_a_in      = boot_a_ff;
      boot_b_in      = boot_b_ff;
      res_kind_in    = res_kind_ff;
      res_set_in     = res_set_ff;
      out_valid_in   = out_valid_ff;
      out_kind_in    = out_kind_ff;
      out_set_in     = out_set_ff;
      out_sending_in = out_sending_ff;

      // register writes
      if (csr_valid && (csr_index < CSR_INDEX_BITS'(KIND_COUNT))) begin
         period_in[csr_index] = csr_data;
      end

      // accepted request word
      if (cmd.accept) begin
         res_kind_in = KIND_NONE;
         res_set_in  = 1'b0;
         case (cmd_type'(req_command))
            CMD_SENT: begin
               if (bus_wanted_ff) begin
                  // hand the bus to mainline
                  saved_in      = sending_ff;
                  sending_in    = 1'b0;
                  mainline_in   = 1'b1;
                  bus_wanted_in = 1'b0;
               end else begin
                  mainline_in = 1'b0;
                  if (no_meas || !have_cells) begin
                     sending_in = 1'b0;
                  end else begin
                     sending_in = mainline_ff ? saved_ff : sending_ff;
                  end
                  cells_set_in = !req_cells_a_valid;
                  boot_a_in    = req_boot_a_valid;
                  boot_b_in    = req_boot_b_valid;
                  pass_in      = '0;
               end
            end
            CMD_START: begin
               if (!sending_ff && have_cells) begin
                  res_kind_in = KIND_STATUS;
                  res_set_in  = !req_cells_a_valid;
                  sending_in  = 1'b1;
               end
            end
            CMD_BUS: begin
               bus_wanted_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // search step
      if (cmd.step_en) begin
         if (last) begin
            step_in  = '0;
            count_in = (count_inc > max_period) ? '0 : count_inc;
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
         if (pass_end) begin
            pass_in = pass_ff + PASS_BITS'(1);
         end
         if (found) begin
            res_kind_in = kind_type'(step_ff + STEP_BITS'(1));
            if (step_ff <= LAST_CELL_STEP) begin
               res_set_in = cells_set_ff;
            end else if (step_ff == BOOT_STEP) begin
               res_set_in = !boot_a_ff;
            end else begin
               res_set_in = 1'b0;
            end
         end else if (pass_end && (pass_ff == LAST_PASS)) begin
            res_kind_in = KIND_NONE;
            res_set_in  = 1'b0;
            sending_in  = 1'b0;
         end
      end

      // output register
      if (cmd.load_out) begin
         out_valid_in   = 1'b1;
         out_kind_in    = res_kind_ff;
         out_set_in     = res_set_ff;
         out_sending_in = sending_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KIND_COUNT; i++) begin
            period_ff[i] <= '0;
         end
         bus_wanted_ff <= 1'b0;
         step_ff       <= '0;
         count_ff      <= PERIOD_BITS'(1);
         sending_ff    <= 1'b0;
         saved_ff      <= 1'b0;
         mainline_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         bus_wanted_ff <= bus_wanted_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         sending_ff    <= sending_in;
         saved_ff      <= saved_in;
         mainline_ff   <= mainline_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pass_ff        <= pass_in;
      cells_set_ff   <= cells_set_in;
      boot_a_ff      <= boot_a_in;
      boot_b_ff      <= boot_b_in;
      res_kind_ff    <= res_kind_in;
      res_set_ff     <= res_set_in;
      out_kind_ff    <= out_kind_in;
      out_set_ff     <= out_set_in;
      out_sending_ff <= out_sending_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_packet_kind    = out_kind_ff;
   assign rsp_data_set       = out_set_ff;
   assign rsp_sending_active = out_sending_ff;

endmodule

`default_nettype wire

FILE: src/telemetry_packet_scheduler_unit.sv
// ----------------------------------------------------------------------------
// telemetry_packet_scheduler_unit
// Picks the next telemetry packet kind from six period registers.
//
// Channels: req_port takes one command word (packet sent, start sending,
// mainline wants bus) with measurement status; rsp_port returns one word
// per request with packet kind, reading set and the sending flag; csr_port
// writes the six period registers (index 0..5, other indexes dropped) and
// is always ready.
// Commands that need no search go to the load state and enter the output
// register once it is free. A "packet sent" word walks the kinds one step
// per cycle: each pass covers one to six kinds, ending at the first kind
// not yet due or after the last kind, for at most 255 passes; the result
// registers take the pick when found. One walk step unit does the search;
// a new word is taken once the previous one has moved to the output register.
// Reset clears all periods, the walk (count 1, step 0), the handover flags
// and the output register. A stalled receiver holds the output word; one
// further request can be processed behind it, then req_port.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_packet_scheduler_unit import tps_pkg::*; #(
   parameter int PERIOD_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   tps_req_if.sink       req_port,
   tps_rsp_if.source     rsp_port,
   tps_csr_if.sink       csr_port
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   assign req_port.ready = ctrl_cmd.req_ready;
   assign csr_port.ready = 1'b1;

   // sequencer
   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // registers and walk logic
   tps_dpath #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .req_command        (req_port.command),
      .req_system_state   (req_port.system_state),
      .req_cells_a_valid  (req_port.cells_a_valid),
      .req_cells_b_valid  (req_port.cells_b_valid),
      .req_boot_a_valid   (req_port.boot_a_valid),
      .req_boot_b_valid   (req_port.boot_b_valid),
      .csr_valid          (csr_port.valid),
      .csr_index          (csr_port.index),
      .csr_data           (csr_port.data),
      .rsp_ready          (rsp_port.ready),
      .rsp_valid          (rsp_port.valid),
      .rsp_packet_kind    (rsp_port.packet_kind),
      .rsp_data_set       (rsp_port.data_set),
      .rsp_sending_active (rsp_port.sending_active)
   );

endmodule

`default_nettype wire

FILE: src/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker
// Port level checks of the telemetry packet scheduler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_checker import tps_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [KIND_BITS-1:0] packet_kind,
   input logic                 data_set,
   input logic                 sending_active
);

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(packet_kind) && $stable(data_set) &&
         $stable(sending_active))
      else $error("stalled response changed");

   // one word at a time: busy the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   // no reading set for none, balance or charge
   a_set_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (packet_kind == KIND_NONE || packet_kind == KIND_BALANCE ||
                    packet_kind == KIND_CHARGE) |-> !data_set)
      else $error("reading set on a kind without one");

endmodule

bind telemetry_packet_scheduler_unit tps_checker u_tps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .packet_kind    (rsp_port.packet_kind),
   .data_set       (rsp_port.data_set),
   .sending_active (rsp_port.sending_active)
);

`default_nettype wire

FILE: tb/sv/telemetry_packet_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// telemetry_packet_scheduler_unit_tb
// Self-checking bench for the telemetry packet scheduler. A queue-fed driver
// offers command words while a receiver takes result words. Both sides idle
// at random, and once the receiver holds off for a long stretch. Each
// accepted word runs through a cycle-free scheduler model that keeps its own
// copy of the periods and the walk state. The model's pick is compared
// field by field with the word that comes back. The period registers are
// reprogrammed between phases, including all-255; reset leaves them all zero.
// ----------------------------------------------------------------------------
module telemetry_packet_scheduler_unit_tb import tps_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD_BITS     = 8;
   localparam int WATCHDOG_LIMIT  = 8000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;

   // command code the block must ignore
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_STATUS_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHARGE_PERIOD  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED_LO    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED_HI    = 3'd7;

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [STATE_BITS-1:0] system_state;
      logic                  cells_a;
      logic                  cells_b;
      logic                  boot_a;
      logic                  boot_b;
   } sched_word_type;

   typedef struct packed {
      kind_type kind;
      logic     data_set;
      logic     sending;
   } packet_pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tps_req_if req_if ();
   tps_rsp_if rsp_if ();
   tps_csr_if #(.DATA_BITS(PERIOD_BITS)) csr_if ();

   telemetry_packet_scheduler_unit #(.PERIOD_BITS(PERIOD_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // scheduler model state, reset values
   logic [PERIOD_BITS-1:0] period_q [KIND_COUNT] = '{default: '0};
   bit                     handover_pending = 1'b0;
   int                     walk_step        = 0;
   logic [PERIOD_BITS-1:0] walk_count       = PERIOD_BITS'(1);
   bit                     telemetry_on     = 1'b0;
   bit                     telemetry_saved  = 1'b0;
   bit                     mainline_owned   = 1'b0;

   sched_word_type  word_queue [$];
   packet_pick_type pick_queue [$];

   int words_issued      = 0;
   int words_accepted    = 0;
   int mismatch_count    = 0;
   int idle_cycles       = 0;
   int sender_idle_pct   = 21;
   int receiver_idle_pct = 85;
   int hold_requests     = 0;
   int hold_served       = 0;
   int hold_left         = 0;
   bit req_taken         = 1'b0;

   // clock
   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // next pick for one accepted word; updates the model state
   function automatic packet_pick_type predict_pick(input sched_word_type w);
      packet_pick_type        pick;
      logic [PERIOD_BITS-1:0] widest;
      logic                   cell_set;
      int                     sweep;
      int                     k;
      int                     j;
      pick.kind     = KIND_NONE;
      pick.data_set = 1'b0;
      case (w.command)
         CMD_SENT: begin
            if (handover_pending) begin
               // give the bus to mainline, keep the flag for later
               telemetry_saved  = telemetry_on;
               telemetry_on     = 1'b0;
               mainline_owned   = 1'b1;
               handover_pending = 1'b0;
            end else begin
               if (mainline_owned) begin
                  mainline_owned = 1'b0;
                  telemetry_on   = telemetry_saved;
               end
               if (w.system_state == SYS_OFF || w.system_state == SYS_HALT ||
                   !(w.cells_a || w.cells_b)) begin
                  telemetry_on = 1'b0;
               end else begin
                  cell_set = !w.cells_a;
                  for (sweep = 0; sweep < SEARCH_LIMIT && pick.kind == KIND_NONE;
                       sweep++) begin
                     // one pass: disabled kinds fall through to the next step
                     for (k = 0; k < KIND_COUNT; k++) begin
                        if (walk_step == k && walk_count >= period_q[k]) begin
                           if (period_q[k] == '0) begin
                              walk_step++;
                           end else if (k == BOOT_STEP) begin
                              if (w.boot_a || w.boot_b) begin
                                 pick.kind     = KIND_BOOT;
                                 pick.data_set = !w.boot_a;
                                 break;
                              end
                              walk_step++;
                           end else begin
                              pick.kind     = kind_type'(k + 1);
                              pick.data_set = (k <= LAST_CELL_STEP) ? cell_set : 1'b0;
                              break;
                           end
                        end
                     end
                     walk_step++;
                     if (walk_step >= KIND_COUNT) begin
                        walk_step  = 0;
                        walk_count = walk_count + 1'b1;
                        widest     = '0;
                        for (j = 0; j < KIND_COUNT; j++) begin
                           if (period_q[j] > widest) widest = period_q[j];
                        end
                        if (walk_count > widest) walk_count = '0;
                     end
                  end
                  if (pick.kind == KIND_NONE) telemetry_on = 1'b0;
               end
            end
         end
         CMD_START: begin
            if (!telemetry_on && (w.cells_a || w.cells_b)) begin
               pick.kind     = KIND_STATUS;
               pick.data_set = !w.cells_a;
               telemetry_on  = 1'b1;
            end
         end
         CMD_BUS: begin
            handover_pending = 1'b1;
         end
         default: begin
         end
      endcase
      pick.sending = telemetry_on;
      return pick;
   endfunction

   function automatic sched_word_type make_word(input logic [CMD_BITS-1:0] command,
                                                input logic [STATE_BITS-1:0] system_state,
                                                input logic ca, input logic cb,
                                                input logic ba, input logic bb);
      sched_word_type w;
      w.command      = command;
      w.system_state = system_state;
      w.cells_a      = ca;
      w.cells_b      = cb;
      w.boot_a       = ba;
      w.boot_b       = bb;
      return w;
   endfunction

   // mostly well-formed traffic: packet-sent words in a measuring state
   function automatic sched_word_type random_word();
      sched_word_type w;
      int             roll;
      roll = $urandom_range(99);
      if (roll < 72)      w.command = CMD_SENT;
      else if (roll < 84) w.command = CMD_START;
      else if (roll < 94) w.command = CMD_BUS;
      else                w.command = CMD_UNUSED;
      w.system_state = STATE_BITS'($urandom_range(7));
      if ((w.system_state == SYS_OFF || w.system_state == SYS_HALT) &&
          $urandom_range(99) < 70) begin
         w.system_state = w.system_state + 1'b1;
      end
      w.cells_a = ($urandom_range(99) < 75);
      w.cells_b = ($urandom_range(99) < 60);
      w.boot_a  = 1'($urandom_range(1));
      w.boot_b  = 1'($urandom_range(1));
      return w;
   endfunction

   task automatic queue_word(input sched_word_type w);
      word_queue.push_back(w);
      words_issued++;
   endtask

   // block is idle once every word is taken and every result is back
   task automatic wait_drain();
      do @(negedge clock);
      while (words_accepted != words_issued || pick_queue.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [PERIOD_BITS-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_periods(input logic [KIND_COUNT-1:0][PERIOD_BITS-1:0] periods);
      logic [CSR_INDEX_BITS-1:0] index;
      for (index = REG_STATUS_PERIOD; index <= REG_CHARGE_PERIOD; index++) begin
         write_register(index, periods[index]);
      end
   endtask

   // command word driver
   always @(negedge clock) begin : word_driver
      sched_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (word_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            w = word_queue.pop_front();
            req_if.valid         <= 1'b1;
            req_if.command       <= w.command;
            req_if.system_state  <= w.system_state;
            req_if.cells_a_valid <= w.cells_a;
            req_if.cells_b_valid <= w.cells_b;
            req_if.boot_a_valid  <= w.boot_a;
            req_if.boot_b_valid  <= w.boot_b;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin : pick_receiver
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // handshake monitor: check results, predict accepted words, track registers
   always @(posedge clock) begin : pick_monitor
      packet_pick_type want;
      sched_word_type  seen;
      bit              moved;
      moved     = 1'b0;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (pick_queue.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, kind %0d",
                                         rsp_if.packet_kind));
            end else begin
               want = pick_queue.pop_front();
               if (rsp_if.packet_kind !== want.kind)
                  report_mismatch($sformatf("packet_kind got %0d want %0d",
                                            rsp_if.packet_kind, want.kind));
               if (rsp_if.data_set !== want.data_set)
                  report_mismatch($sformatf("data_set got %0d want %0d",
                                            rsp_if.data_set, want.data_set));
               if (rsp_if.sending_active !== want.sending)
                  report_mismatch($sformatf("sending_active got %0d want %0d",
                                            rsp_if.sending_active, want.sending));
            end
         end
         if (req_if.valid && req_if.ready) begin
            moved             = 1'b1;
            req_taken         = 1'b1;
            seen.command      = req_if.command;
            seen.system_state = req_if.system_state;
            seen.cells_a      = req_if.cells_a_valid;
            seen.cells_b      = req_if.cells_b_valid;
            seen.boot_a       = req_if.boot_a_valid;
            seen.boot_b       = req_if.boot_b_valid;
            pick_queue.push_back(predict_pick(seen));
            words_accepted++;
         end
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            if (csr_if.index < KIND_COUNT) period_q[csr_if.index] = csr_if.data;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      logic [KIND_COUNT-1:0][PERIOD_BITS-1:0] periods;
      int                                     phase_no;
      int                                     n;
      int                                     count;
      int                                     i;

      req_if.valid         = 1'b0;
      req_if.command       = CMD_SENT;
      req_if.system_state  = SYS_OFF;
      req_if.cells_a_valid = 1'b0;
      req_if.cells_b_valid = 1'b0;
      req_if.boot_a_valid  = 1'b0;
      req_if.boot_b_valid  = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = REG_STATUS_PERIOD;
      csr_if.data          = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all kinds disabled after reset
      @(posedge clock);
      queue_word(make_word(CMD_START, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_START, 3'd2, 1'b1, 1'b1, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd7, 1'b1, 1'b0, 1'b1, 1'b0));
      queue_word(make_word(CMD_UNUSED, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1));
      wait_drain();

      // unmapped indexes are dropped, then a short ladder of periods
      write_register(REG_UNMAPPED_LO, '1);
      write_register(REG_UNMAPPED_HI, PERIOD_BITS'($urandom_range(255)));
      program_periods({8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1});
      @(posedge clock);
      queue_word(make_word(CMD_START, 3'd2, 1'b0, 1'b1, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd3, 1'b0, 1'b1, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd5, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd6, 1'b1, 1'b0, 1'b0, 1'b1));
      queue_word(make_word(CMD_SENT,  3'd7, 1'b1, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(CMD_SENT,  SYS_OFF, 1'b1, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(CMD_START, 3'd1, 1'b0, 1'b0, 1'b1, 1'b1));
      queue_word(make_word(CMD_START, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0));
      // handover to mainline and back
      queue_word(make_word(CMD_BUS,   3'd1, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd1, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd1, 1'b1, 1'b0, 1'b1, 1'b0));
      queue_word(make_word(CMD_BUS,   3'd6, 1'b0, 1'b1, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd6, 1'b0, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  SYS_HALT, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(CMD_SENT,  3'd3, 1'b0, 1'b0, 1'b1, 1'b0));
      for (i = 0; i < 6; i++) begin
         queue_word(make_word(CMD_SENT, 3'd5, 1'b0, 1'b1, i[0], i[1]));
      end
      wait_drain();

      // random phases: idle mix changes, periods change between phases
      for (phase_no = 0; phase_no < 5; phase_no++) begin
         case (phase_no)
            0: begin
               for (i = 0; i < KIND_COUNT; i++) periods[i] = PERIOD_BITS'($urandom_range(12));
               count = 280;
            end
            1: begin
               periods = {8'd7, 8'd2, 8'd3, 8'd0, 8'd1, 8'd255};
               count   = 280;
            end
            2: begin
               periods = '1;
               count   = 40;
            end
            3: begin
               for (i = 0; i < KIND_COUNT; i++) periods[i] = PERIOD_BITS'($urandom_range(1, 6));
               count = 300;
            end
            default: begin
               for (i = 0; i < KIND_COUNT; i++) periods[i] = PERIOD_BITS'($urandom_range(10));
               count = 100;
            end
         endcase
         program_periods(periods);
         @(posedge clock);
         sender_idle_pct   = (phase_no == 0) ? 21 : (phase_no == 1) ? 85 : 0;
         receiver_idle_pct = (phase_no == 0) ? 85 : (phase_no == 1) ? 21 : 0;
         for (n = 0; n < count; n++) queue_word(random_word());
         // last phase: receiver stalls while the sender keeps offering
         if (phase_no == 4) hold_requests++;
         wait_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (pick_queue.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", pick_queue.size()));
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
